// ----- src/lvq_pkg.sv -----
// lvq_pkg: shared widths, command and kind codes, FSM states and saturation helpers
// for the LVQ prototype trainer. Depends on nothing.
package lvq_pkg;

  localparam int VECTOR_DIM_DEF  = 16;
  localparam int NUM_CLASSES_DEF = 8;

  localparam int CMD_W    = 3;
  localparam int LABEL_W  = 3;
  localparam int VAL_W    = 16;
  localparam int RATE_W   = 16;
  localparam int KIND_W   = 2;
  localparam int CLASS_W  = 3;
  localparam int ACC_W    = 40;
  localparam int CNT_W    = 20;
  localparam int DIST_W   = 48;
  localparam int SQ_W     = 34;
  localparam int PROD_W   = ACC_W + RATE_W;
  localparam int Q_W      = 42;
  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 8;

  localparam logic [CMD_W-1:0] CMD_INIT     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_TRAIN    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLASSIFY = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FINISH   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_EPOCH    = 3'd4;

  localparam logic [KIND_W-1:0] KIND_CLASSIFY = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TRAIN    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE     = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIST,
    ST_INIT_RD,
    ST_INIT_WR,
    ST_SCAN,
    ST_CLOSE,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_SWP_RD,
    ST_SWP_MUL,
    ST_SWP_DIV,
    ST_SWP_WR,
    ST_RESULT
  } state_t;

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
    logic signed [ACC_W:0] hi;
    logic signed [ACC_W:0] lo;
    hi = (ACC_W+1)'({1'b0, {(ACC_W-1){1'b1}}});
    lo = -hi - (ACC_W+1)'(1);
    if (v > hi) return hi[ACC_W-1:0];
    if (v < lo) return lo[ACC_W-1:0];
    return v[ACC_W-1:0];
  endfunction

  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [Q_W-1:0] v);
    logic signed [Q_W-1:0] hi;
    logic signed [Q_W-1:0] lo;
    hi = Q_W'(32767);
    lo = -Q_W'(32768);
    if (v > hi) return hi[VAL_W-1:0];
    if (v < lo) return lo[VAL_W-1:0];
    return v[VAL_W-1:0];
  endfunction

endpackage

// ----- src/lvq_ram.sv -----
// lvq_ram: simple dual-port synchronous RAM, one write and one registered read per cycle.
// No dependencies.
module lvq_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/lvq_div.sv -----
// lvq_div: restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
module lvq_div #(
  parameter int NW = 56,
  parameter int DW = 20
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [NW-1:0] nsh;
  logic [DW-1:0] rem;
  logic [DW-1:0] den_r;
  logic [DW:0]   trial;
  logic          fit;

  assign trial = {rem, nsh[NW-1]};
  assign fit   = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CW'(NW);
        nsh   <= num;
        rem   <= '0;
        quo   <= '0;
        den_r <= den;
      end else if (busy) begin
        rem <= fit ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
        quo <= {quo[NW-2:0], fit};
        nsh <= {nsh[NW-2:0], 1'b0};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- src/lvq_prototype_classifier_trainer_unit.sv -----
// lvq_prototype_classifier_trainer_unit: LVQ1 batch trainer/classifier top level.
// Uses lvq_pkg, lvq_ram (prototypes, delta sums, sample buffer) and lvq_div.
//
//  channel | dir | beat contents
//  s_*     | in  | tuser=cmd[2:0]; tdata=label[2:0],value[18:3],rate[34:19]; tlast=last
//  m_*     | out | tuser=kind[1:0]; tdata=class_index[2:0],matched[3]
//
// Element beat: every prototype is read through the prototype RAM read port; init adds a delta read and write.
// Vector close: a nearest scan over all classes, plus a read and a write per element for a train update.
// Finish init / epoch end: per cell, the delta sum is divided by the class hit count in lvq_div.
// After reset a clearing pass over all NUM_CLASSES*VECTOR_DIM cells runs before s_tready.
// Output register decouples m_tready: a new beat is taken while a result waits.
module lvq_prototype_classifier_trainer_unit #(
  parameter int VECTOR_DIM  = lvq_pkg::VECTOR_DIM_DEF,
  parameter int NUM_CLASSES = lvq_pkg::NUM_CLASSES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [lvq_pkg::S_DATA_W-1:0] s_tdata,   // label, value, rate, zero pad
  input  logic [lvq_pkg::CMD_W-1:0]    s_tuser,   // cmd
  input  logic                         s_tlast,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [lvq_pkg::M_DATA_W-1:0] m_tdata,   // class_index, matched, zero pad
  output logic [lvq_pkg::KIND_W-1:0]   m_tuser    // kind
);
  import lvq_pkg::*;

  localparam int CELLS = NUM_CLASSES * VECTOR_DIM;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CW    = $clog2(NUM_CLASSES);
  localparam int IW    = (VECTOR_DIM > 1) ? $clog2(VECTOR_DIM) : 1;
  localparam int EW    = $clog2(VECTOR_DIM + 1);
  localparam int NCW   = $clog2(NUM_CLASSES + 2);

  state_t state, state_next;

  logic [CMD_W-1:0]        cmd_r;
  logic [LABEL_W-1:0]      label_r;
  logic signed [VAL_W-1:0] value_r;
  logic                    last_r;
  logic [RATE_W-1:0]       rate_r;

  logic [EW-1:0]     ei;
  logic [DIST_W-1:0] dist_sum [NUM_CLASSES];
  logic [CNT_W-1:0]  hit  [NUM_CLASSES];
  logic [NCW-1:0]    cnt;
  logic [CW-1:0]     cnt_c;
  logic [IW-1:0]     cnt_i;
  logic [CW-1:0]     best;
  logic [DIST_W-1:0] best_d;
  logic              match_r;

  logic            p1_v, p2_v;
  logic [CW-1:0]   p1_c, p2_c;
  logic [SQ_W-1:0] sq_r;

  logic                    neg_r, zero_r;
  logic signed [VAL_W-1:0] proto_h;

  logic [KIND_W-1:0]  res_kind;
  logic [CLASS_W-1:0] res_class;
  logic               res_match;

  // memories
  logic [AW-1:0]    rd_addr;
  logic             proto_we, delta_we, sb_we;
  logic [VAL_W-1:0] proto_wd, proto_rd, sb_rd;
  logic [ACC_W-1:0] delta_wd, delta_rd;
  logic [IW-1:0]    sb_waddr, sb_raddr;

  logic accept, init_add, last_cell, upd_done, match_now;
  logic [CW-1:0] idx;

  logic signed [VAL_W-1:0] proto_s, sb_s;
  logic signed [ACC_W-1:0] delta_s;
  logic signed [VAL_W:0]   dd, ud, uadd;
  logic signed [SQ_W-1:0]  dsq;
  logic [ACC_W-1:0]        mag;
  logic [PROD_W-1:0]       div_num, quo;
  logic                    div_start, div_done;
  logic signed [Q_W-1:0]   qmag, qs, qsum;

  function automatic logic [AW-1:0] cell_addr(input int c, input int i);
    return AW'(c * VECTOR_DIM + i);
  endfunction

  lvq_ram #(.W(VAL_W), .DEPTH(CELLS), .AW(AW)) u_proto (
    .clk(clk), .we(proto_we), .waddr(rd_addr), .wdata(proto_wd),
    .raddr(rd_addr), .rdata(proto_rd)
  );

  lvq_ram #(.W(ACC_W), .DEPTH(CELLS), .AW(AW)) u_delta (
    .clk(clk), .we(delta_we), .waddr(rd_addr), .wdata(delta_wd),
    .raddr(rd_addr), .rdata(delta_rd)
  );

  lvq_ram #(.W(VAL_W), .DEPTH(VECTOR_DIM), .AW(IW)) u_sbuf (
    .clk(clk), .we(sb_we), .waddr(sb_waddr), .wdata(s_tdata[LABEL_W +: VAL_W]),
    .raddr(sb_raddr), .rdata(sb_rd)
  );

  lvq_div #(.NW(PROD_W), .DW(CNT_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(hit[cnt_c]),
    .done(div_done), .quo(quo)
  );

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign idx       = cnt[CW-1:0];
  assign init_add  = (cmd_r == CMD_INIT) && (int'(label_r) < NUM_CLASSES);
  assign last_cell = (int'(cnt_c) == NUM_CLASSES - 1) && (int'(cnt_i) == VECTOR_DIM - 1);
  assign upd_done  = (int'(cnt_i) + 1 == int'(ei));
  assign match_now = (int'(best) == int'(label_r));
  assign sb_waddr  = ei[IW-1:0];
  assign sb_raddr  = cnt_i;
  assign sb_we     = accept && (s_tuser <= CMD_CLASSIFY) && (int'(ei) < VECTOR_DIM);

  assign proto_s = signed'(proto_rd);
  assign sb_s    = signed'(sb_rd);
  assign delta_s = signed'(delta_rd);
  assign dd      = (VAL_W+1)'(value_r) - (VAL_W+1)'(proto_s);
  assign dsq     = dd * dd;
  assign ud      = (VAL_W+1)'(sb_s) - (VAL_W+1)'(proto_s);
  assign uadd    = match_r ? ud : -ud;
  assign mag     = delta_s[ACC_W-1] ? ACC_W'(-delta_s) : ACC_W'(delta_s);
  assign div_num = (cmd_r == CMD_EPOCH) ? PROD_W'(mag) * PROD_W'(rate_r) : PROD_W'(mag);
  assign qmag    = zero_r ? '0 :
                   ((cmd_r == CMD_EPOCH) ? Q_W'(quo >> RATE_W) : Q_W'(quo));
  assign qs      = neg_r ? -qmag : qmag;
  assign qsum    = qs + ((cmd_r == CMD_EPOCH) ? Q_W'(proto_h) : Q_W'(0));

  always_comb begin
    state_next = state;
    rd_addr    = cell_addr(int'(cnt_c), int'(cnt_i));
    proto_we   = 1'b0;
    delta_we   = 1'b0;
    proto_wd   = '0;
    delta_wd   = '0;
    div_start  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        proto_we = 1'b1;
        delta_we = 1'b1;
        if (last_cell) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (s_tuser <= CMD_CLASSIFY) begin
            if (int'(ei) < VECTOR_DIM) state_next = ST_DIST;
            else if (s_tlast) state_next = ST_SCAN;
          end else if (s_tuser == CMD_FINISH || s_tuser == CMD_EPOCH) begin
            state_next = ST_SWP_RD;
          end
        end
      end
      ST_DIST: begin
        rd_addr = cell_addr(int'(idx), int'(ei[IW-1:0]));
        if (int'(cnt) == NUM_CLASSES + 1) begin
          if (init_add) state_next = ST_INIT_RD;
          else state_next = last_r ? ST_SCAN : ST_IDLE;
        end
      end
      ST_INIT_RD: begin
        rd_addr    = cell_addr(int'(label_r), int'(ei[IW-1:0]));
        state_next = ST_INIT_WR;
      end
      ST_INIT_WR: begin
        rd_addr    = cell_addr(int'(label_r), int'(ei[IW-1:0]));
        delta_we   = 1'b1;
        delta_wd   = sat_acc((ACC_W+1)'(delta_s) + (ACC_W+1)'(value_r));
        state_next = last_r ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        if (int'(cnt) == NUM_CLASSES - 1) state_next = ST_CLOSE;
      end
      ST_CLOSE: begin
        if (cmd_r == CMD_INIT) state_next = ST_IDLE;
        else if (cmd_r == CMD_TRAIN && ei != '0) state_next = ST_UPD_RD;
        else state_next = ST_RESULT;
      end
      ST_UPD_RD: begin
        rd_addr    = cell_addr(int'(best), int'(cnt_i));
        state_next = ST_UPD_WR;
      end
      ST_UPD_WR: begin
        rd_addr    = cell_addr(int'(best), int'(cnt_i));
        delta_we   = 1'b1;
        delta_wd   = sat_acc((ACC_W+1)'(delta_s) + (ACC_W+1)'(uadd));
        state_next = upd_done ? ST_RESULT : ST_UPD_RD;
      end
      ST_SWP_RD: state_next = ST_SWP_MUL;
      ST_SWP_MUL: begin
        if (hit[cnt_c] == '0) begin
          state_next = ST_SWP_WR;
        end else begin
          div_start  = 1'b1;
          state_next = ST_SWP_DIV;
        end
      end
      ST_SWP_DIV: begin
        if (div_done) state_next = ST_SWP_WR;
      end
      ST_SWP_WR: begin
        delta_we   = 1'b1;
        // epoch end leaves untouched prototypes of classes with no hits
        proto_we   = !(zero_r && cmd_r == CMD_EPOCH);
        proto_wd   = sat_val(qsum);
        state_next = last_cell ? ST_RESULT : ST_SWP_RD;
      end
      ST_RESULT: begin
        if (!m_tvalid || m_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      ei       <= '0;
      cnt      <= '0;
      cnt_c    <= '0;
      cnt_i    <= '0;
      p1_v     <= 1'b0;
      p2_v     <= 1'b0;
      m_tvalid <= 1'b0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        dist_sum[c] <= '0;
        hit[c]      <= '0;
      end
    end else begin
      state <= state_next;
      p1_v  <= (state == ST_DIST) && (int'(cnt) < NUM_CLASSES);
      p1_c  <= idx;
      p2_v  <= p1_v;
      p2_c  <= p1_c;
      sq_r  <= SQ_W'(dsq);
      if (p2_v) dist_sum[p2_c] <= dist_sum[p2_c] + DIST_W'(sq_r);
      if (m_tvalid && m_tready && state != ST_RESULT) m_tvalid <= 1'b0;

      case (state)
        ST_CLEAR, ST_SWP_WR: begin
          if (int'(cnt_i) == VECTOR_DIM - 1) begin
            cnt_i <= '0;
            cnt_c <= (int'(cnt_c) == NUM_CLASSES - 1) ? '0 : cnt_c + CW'(1);
          end else begin
            cnt_i <= cnt_i + IW'(1);
          end
          if (state == ST_SWP_WR && last_cell) begin
            for (int c = 0; c < NUM_CLASSES; c++) hit[c] <= '0;
            res_kind  <= KIND_DONE;
            res_class <= '0;
            res_match <= 1'b0;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            cmd_r   <= s_tuser;
            label_r <= s_tdata[LABEL_W-1:0];
            value_r <= signed'(s_tdata[LABEL_W +: VAL_W]);
            rate_r  <= s_tdata[LABEL_W+VAL_W +: RATE_W];
            last_r  <= s_tlast;
            cnt     <= '0;
            cnt_c   <= '0;
            cnt_i   <= '0;
            if (s_tuser == CMD_FINISH || s_tuser == CMD_EPOCH) begin
              ei <= '0;
              for (int c = 0; c < NUM_CLASSES; c++) dist_sum[c] <= '0;
            end
          end
        end
        ST_DIST: begin
          if (int'(cnt) == NUM_CLASSES + 1) begin
            cnt <= '0;
            if (!init_add) ei <= ei + EW'(1);
          end else begin
            cnt <= cnt + NCW'(1);
          end
        end
        ST_INIT_WR: begin
          ei  <= ei + EW'(1);
          cnt <= '0;
        end
        ST_SCAN: begin
          if (cnt == '0 || dist_sum[idx] < best_d) begin
            best   <= idx;
            best_d <= dist_sum[idx];
          end
          cnt <= cnt + NCW'(1);
        end
        ST_CLOSE: begin
          match_r   <= match_now;
          cnt_i     <= '0;
          res_class <= CLASS_W'(best);
          if (cmd_r == CMD_INIT) begin
            if (int'(label_r) < NUM_CLASSES && hit[CW'(label_r)] != '1)
              hit[CW'(label_r)] <= hit[CW'(label_r)] + CNT_W'(1);
          end else if (cmd_r == CMD_TRAIN) begin
            res_kind  <= KIND_TRAIN;
            res_match <= match_now;
            if (ei == '0 && hit[best] != '1) hit[best] <= hit[best] + CNT_W'(1);
          end else begin
            res_kind  <= KIND_CLASSIFY;
            res_match <= 1'b0;
          end
          if (cmd_r != CMD_TRAIN || ei == '0) begin
            ei <= '0;
            for (int c = 0; c < NUM_CLASSES; c++) dist_sum[c] <= '0;
          end
        end
        ST_UPD_WR: begin
          cnt_i <= cnt_i + IW'(1);
          if (upd_done) begin
            if (hit[best] != '1) hit[best] <= hit[best] + CNT_W'(1);
            ei <= '0;
            for (int c = 0; c < NUM_CLASSES; c++) dist_sum[c] <= '0;
          end
        end
        ST_SWP_MUL: begin
          neg_r   <= delta_s[ACC_W-1];
          proto_h <= proto_s;
          zero_r  <= (hit[cnt_c] == '0);
        end
        ST_RESULT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_kind;
            m_tdata  <= M_DATA_W'({res_match, res_class});
          end
        end
        default: ;
      endcase
    end
  end

  // checks
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> state == ST_IDLE)
    else $error("ready outside idle");

  a_ei_range: assert property (@(posedge clk) disable iff (rst)
    int'(ei) <= VECTOR_DIM)
    else $error("element index overflow");

  a_kind_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == KIND_CLASSIFY || m_tuser == KIND_TRAIN || m_tuser == KIND_DONE))
    else $error("bad result kind");

  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_TRAIN |-> m_tdata[CLASS_W] == 1'b0)
    else $error("matched set outside train result");

  a_pipe_drained: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> !p1_v && !p2_v)
    else $error("scan while distance pipe busy");

endmodule
